// ===== sv/sha_pkg.sv =====
// SHA-256 shared package: types, constants, round functions.
// No dependencies.
`timescale 1ns / 1ps
package sha_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_COMP,
        ST_ADD,
        ST_OUT
    } state_t;

    // controller -> datapath commands
    typedef struct packed {
        logic       load_byte;   // shift input byte into the block window
        logic       pad_write;   // shift one padding byte into the block window
        logic       pad_marker;  // padding byte is the 0x80 marker
        logic       pad_len;     // bytes 56..63 of this block carry the length
        logic       comp_start;  // load working vars from chain
        logic       round_en;    // run one round
        logic       chain_add;   // fold working vars into chain
        logic       chain_init;  // restore initial hash, clear counters
        logic       fill_clr;    // fill count back to zero
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic [6:0] fill;
        logic       last_round;
    } stat_t;

    localparam logic [31:0] H_INIT [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [6:0] LEN_POS = 7'd56;
    localparam logic [6:0] BLK_BYTES = 7'd64;

    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k [0:63];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef4a3f7,32'hc67178f2
        };
        return k[i];
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

// ===== sv/sha_if.sv =====
// Valid/ready channel interfaces for the SHA-256 block.
// Depends on nothing.
`timescale 1ns / 1ps
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       end_of_message;
    modport source (output valid, msg_byte, byte_valid, end_of_message, input ready);
    modport sink (input valid, msg_byte, byte_valid, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ===== sv/sha_dp.sv =====
// SHA-256 datapath: byte window that doubles as message schedule, round logic, chain.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_dp (
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::cmd_t    cmd,
    input  logic [7:0]       msg_byte,
    input  logic [2:0]       out_idx,
    output sha_pkg::stat_t   stat,
    output logic [31:0]      digest_word
);
    logic [6:0]  fill_reg;
    logic [63:0] len_reg;
    logic [31:0] chain_reg [0:7];
    logic [31:0] s_reg [0:7];
    logic [31:0] w_reg [0:15];
    logic [5:0]  rnd_reg;

    logic [7:0]  pad_val;
    logic [7:0]  shift_byte;
    logic [31:0] w_new, t1, t2, big0, big1, ch, maj, s0, s1;

    // padding byte: marker, zero fill, or big-endian length
    always_comb
    begin
        if (cmd.pad_marker)
            pad_val = sha_pkg::PAD_BYTE;
        else if (cmd.pad_len && fill_reg >= sha_pkg::LEN_POS)
            pad_val = len_reg[{~fill_reg[2:0], 3'b000} +: 8];
        else
            pad_val = 8'h00;
    end

    assign shift_byte = cmd.load_byte ? msg_byte : pad_val;

    assign s0 = sha_pkg::rotr(w_reg[1], 7) ^ sha_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = sha_pkg::rotr(w_reg[14], 17) ^ sha_pkg::rotr(w_reg[14], 19)
              ^ (w_reg[14] >> 10);
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];

    assign big1 = sha_pkg::rotr(s_reg[4], 6) ^ sha_pkg::rotr(s_reg[4], 11)
                ^ sha_pkg::rotr(s_reg[4], 25);
    assign ch   = (s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6]);
    assign t1   = s_reg[7] + big1 + ch + sha_pkg::round_k(rnd_reg) + w_reg[0];
    assign big0 = sha_pkg::rotr(s_reg[0], 2) ^ sha_pkg::rotr(s_reg[0], 13)
                ^ sha_pkg::rotr(s_reg[0], 22);
    assign maj  = (s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]);
    assign t2   = big0 + maj;

    assign stat.fill = fill_reg;
    assign stat.last_round = (rnd_reg == 6'd63);
    assign digest_word = chain_reg[out_idx];

    // 64-byte window: bytes shift in at the bottom, so after 64 of them
    // w_reg[0] holds bytes 0..3 big-endian; rounds then shift it as the schedule
    always_ff @(posedge clk)
    begin
        if (cmd.load_byte || cmd.pad_write)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= {w_reg[i][23:0], w_reg[i+1][31:24]};
            w_reg[15] <= {w_reg[15][23:0], shift_byte};
        end
        else if (cmd.round_en)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
        end
        if (cmd.comp_start)
        begin
            for (int i = 0; i < 8; i++)
                s_reg[i] <= chain_reg[i];
        end
        else if (cmd.round_en)
        begin
            s_reg[7] <= s_reg[6];
            s_reg[6] <= s_reg[5];
            s_reg[5] <= s_reg[4];
            s_reg[4] <= s_reg[3] + t1;
            s_reg[3] <= s_reg[2];
            s_reg[2] <= s_reg[1];
            s_reg[1] <= s_reg[0];
            s_reg[0] <= t1 + t2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
            rnd_reg  <= '0;
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sha_pkg::H_INIT[i];
        end
        else
        begin
            if (cmd.chain_init)
            begin
                fill_reg <= '0;
                len_reg  <= '0;
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= sha_pkg::H_INIT[i];
            end
            else
            begin
                if (cmd.fill_clr)
                    fill_reg <= '0;
                else if (cmd.load_byte || cmd.pad_write)
                    fill_reg <= fill_reg + 7'd1;
                if (cmd.load_byte)
                    len_reg <= len_reg + 64'd8;
                if (cmd.chain_add)
                    for (int i = 0; i < 8; i++)
                        chain_reg[i] <= chain_reg[i] + s_reg[i];
            end
            if (cmd.comp_start)
                rnd_reg <= '0;
            else if (cmd.round_en)
                rnd_reg <= rnd_reg + 6'd1;
        end
    end
endmodule

// ===== sv/sha_ctrl.sv =====
// SHA-256 controller: byte intake, padding sequence, rounds, digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps
module sha_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             byte_valid,
    input  logic             end_of_message,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       out_idx,
    input  sha_pkg::stat_t   stat,
    output sha_pkg::cmd_t    cmd
);
    sha_pkg::state_t state_reg, state_next;
    logic            final_reg, final_next;   // padding pending after this block
    logic            marker_reg, marker_next; // 0x80 already written
    logic [2:0]      idx_reg, idx_next;
    logic            lenblk_reg, lenblk_next; // last compressed block carried the length
    logic            lenwin_reg, lenwin_next; // current pad block carries the length
    logic            accept, blk_full;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == sha_pkg::ST_IDLE);
    assign out_valid = (state_reg == sha_pkg::ST_OUT);
    assign out_idx  = idx_reg;
    assign blk_full = (stat.fill == sha_pkg::BLK_BYTES - 7'd1);

    always_comb
    begin
        state_next  = state_reg;
        final_next  = final_reg;
        marker_next = marker_reg;
        idx_next    = idx_reg;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    final_next  = end_of_message;
                    marker_next = 1'b0;
                    idx_next    = '0;
                    if (byte_valid && blk_full)
                        state_next = sha_pkg::ST_COMP;
                    else if (end_of_message)
                        state_next = sha_pkg::ST_PAD;
                end
            end
            sha_pkg::ST_PAD:
            begin
                marker_next = 1'b1;
                if (stat.fill == sha_pkg::BLK_BYTES - 7'd1)
                    state_next = sha_pkg::ST_COMP;
            end
            sha_pkg::ST_COMP:
                if (stat.last_round)
                    state_next = sha_pkg::ST_ADD;
            sha_pkg::ST_ADD:
            begin
                if (!final_reg)
                    state_next = sha_pkg::ST_IDLE;
                else if (lenblk_reg)
                    state_next = sha_pkg::ST_OUT;
                else
                    state_next = sha_pkg::ST_PAD;
            end
            sha_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                        state_next = sha_pkg::ST_IDLE;
                end
            end
            default: state_next = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        lenblk_next = lenblk_reg;
        if (state_reg == sha_pkg::ST_IDLE)
            lenblk_next = 1'b0;
        else if (state_reg == sha_pkg::ST_PAD && stat.fill == sha_pkg::BLK_BYTES - 7'd1)
            lenblk_next = lenwin_reg;
    end

    // the length field goes in the marker's block if the marker lands at or below byte 55, else in the next pad block
    always_comb
    begin
        lenwin_next = lenwin_reg;
        if (state_reg == sha_pkg::ST_IDLE)
            lenwin_next = 1'b0;
        else if (state_reg == sha_pkg::ST_PAD && !marker_reg)
            lenwin_next = (stat.fill < sha_pkg::LEN_POS);
        else if (state_reg == sha_pkg::ST_PAD && marker_reg && stat.fill == 7'd0)
            lenwin_next = 1'b1;
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            sha_pkg::ST_IDLE:
            begin
                cmd.load_byte = accept && byte_valid;
                cmd.comp_start = accept && byte_valid && blk_full;
                cmd.fill_clr = cmd.comp_start;
            end
            sha_pkg::ST_PAD:
            begin
                cmd.pad_write = 1'b1;
                cmd.pad_marker = !marker_reg;
                cmd.pad_len = lenwin_reg;
                cmd.comp_start = (stat.fill == sha_pkg::BLK_BYTES - 7'd1);
                cmd.fill_clr = cmd.comp_start;
            end
            sha_pkg::ST_COMP: cmd.round_en = 1'b1;
            sha_pkg::ST_ADD:  cmd.chain_add = 1'b1;
            sha_pkg::ST_OUT:  cmd.chain_init = out_ready && (idx_reg == 3'd7);
            default: cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sha_pkg::ST_IDLE;
            final_reg  <= 1'b0;
            marker_reg <= 1'b0;
            idx_reg    <= '0;
            lenblk_reg <= 1'b0;
            lenwin_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            final_reg  <= final_next;
            marker_reg <= marker_next;
            idx_reg    <= idx_next;
            lenblk_reg <= lenblk_next;
            lenwin_reg <= lenwin_next;
        end
    end
endmodule

// ===== sv/sha256_hash.sv =====
// SHA-256 hasher top level: wires controller to datapath and the channels.
// Depends on sha_pkg, sha_if, sha_ctrl, sha_dp.
//
//  channel   dir  payload
//  in_ch     in   msg_byte[7:0], byte_valid, end_of_message
//  out_ch    out  digest_word[31:0], word_index[2:0], last_word
//
// A full block loads the working variables from the chain, runs 64 rounds
// and folds them into the chain. End of message writes the padding one
// byte a cycle, compresses one or two blocks, then offers the eight digest
// words, each held until taken. Input is stalled meanwhile. Reset restores
// the initial hash and clears counters at once.
`timescale 1ns / 1ps
module sha256_hash (
    input  logic       clk,
    input  logic       rst_n,
    sha_in_if.sink     in_ch,
    sha_out_if.source  out_ch
);
    sha_pkg::cmd_t  cmd;
    sha_pkg::stat_t stat;
    logic [2:0]     idx;
    logic [31:0]    word;

    sha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_ch.valid),
        .in_ready       (in_ch.ready),
        .byte_valid     (in_ch.byte_valid),
        .end_of_message (in_ch.end_of_message),
        .out_valid      (out_ch.valid),
        .out_ready      (out_ch.ready),
        .out_idx        (idx),
        .stat           (stat),
        .cmd            (cmd)
    );

    sha_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .msg_byte    (in_ch.msg_byte),
        .out_idx     (idx),
        .stat        (stat),
        .digest_word (word)
    );

    assign out_ch.digest_word = word;
    assign out_ch.word_index  = idx;
    assign out_ch.last_word   = (idx == 3'd7);
endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for sha256_hash: byte-serial SHA-256 predictor and scoreboard.
// Depends on sha_if and the sha256_hash RTL.
`timescale 1ns / 1ps
module tb_top;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_valid;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_ITEMS = 36;

    // SHA-256 round constants, kept locally for the predictor
    localparam logic [31:0] K_TAB [0:63] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef4a3f7,32'hc67178f2
    };
    localparam logic [31:0] IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    logic clk;
    logic rst_n;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_hash uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // 20 ns period
    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // ---------------------------------------------------------------
    // Predictor state: chain, block buffer, fill count, bit length
    // ---------------------------------------------------------------
    logic [31:0] hash_chain [0:7];
    logic [7:0]  blk_buf [0:63];
    int          blk_fill;
    logic [63:0] bit_len;

    msg_item_t    pending_bytes[$];   // items waiting for the driver
    digest_item_t digest_queue[$];    // predicted digest words in order

    int  error_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    bit  hold_off = 1'b0;
    bit  in_fire = 1'b0;              // input item taken at the last rising edge
    longint cycle_count = 0;

    function automatic logic [31:0] ror(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic void hash_restart();
        for (int i = 0; i < 8; i++)
            hash_chain[i] = IV[i];
        blk_fill = 0;
        bit_len = '0;
    endfunction

    // one 64-round compression of blk_buf into hash_chain
    function automatic void compress_blk();
        logic [31:0] w [0:63];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk_buf[4*i], blk_buf[4*i+1], blk_buf[4*i+2], blk_buf[4*i+3]};
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        {a, b, c, d, e, f, g, h} = {hash_chain[0], hash_chain[1], hash_chain[2],
            hash_chain[3], hash_chain[4], hash_chain[5], hash_chain[6], hash_chain[7]};
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & f) ^ (~e & g))
                 + K_TAB[i] + w[i];
            t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) ^ 32'h0;
            t2 = t2 + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_chain[0] += a; hash_chain[1] += b; hash_chain[2] += c; hash_chain[3] += d;
        hash_chain[4] += e; hash_chain[5] += f; hash_chain[6] += g; hash_chain[7] += h;
    endfunction

    // apply one accepted item; pushes eight digest words on end of message
    function automatic void predict_digest(msg_item_t it);
        if (it.byte_valid)
        begin
            blk_buf[blk_fill] = it.msg_byte;
            blk_fill++;
            bit_len += 64'd8;
            if (blk_fill == 64)
            begin
                compress_blk();
                blk_fill = 0;
            end
        end
        if (!it.end_of_message)
            return;
        blk_buf[blk_fill] = 8'h80;
        blk_fill++;
        if (blk_fill > 56)
        begin
            while (blk_fill < 64)
                blk_buf[blk_fill++] = 8'h00;
            compress_blk();
            blk_fill = 0;
        end
        while (blk_fill < 56)
            blk_buf[blk_fill++] = 8'h00;
        for (int i = 0; i < 8; i++)
            blk_buf[56+i] = bit_len[63 - 8*i -: 8];
        compress_blk();
        for (int i = 0; i < 8; i++)
            digest_queue.push_back('{hash_chain[i], 3'(i), (i == 7)});
        hash_restart();
    endfunction

    // ---------------------------------------------------------------
    // Driver: present items from pending_bytes at the falling edge
    // ---------------------------------------------------------------
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.msg_byte = '0;
        in_ch.byte_valid = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // keep offering the current item until a rising edge takes it
            if (!in_ch.valid || in_fire)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_ch.valid <= 1'b1;
                    {in_ch.msg_byte, in_ch.byte_valid, in_ch.end_of_message}
                        <= pending_bytes.pop_front();
                end
                else
                    in_ch.valid <= 1'b0;
            end
            out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            in_fire <= in_ch.valid && in_ch.ready;
            if (in_ch.valid && in_ch.ready)
                predict_digest({in_ch.msg_byte, in_ch.byte_valid, in_ch.end_of_message});
            if (out_ch.valid && out_ch.ready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $display("%0t: unexpected digest word %h idx %0d last %0b", $time,
                        out_ch.digest_word, out_ch.word_index, out_ch.last_word);
                    error_count++;
                end
                else
                begin
                    digest_item_t exp_w;
                    exp_w = digest_queue.pop_front();
                    if (exp_w.digest_word !== out_ch.digest_word)
                    begin
                        $display("%0t: digest_word expected %h actual %h", $time,
                            exp_w.digest_word, out_ch.digest_word);
                        error_count++;
                    end
                    if (exp_w.word_index !== out_ch.word_index)
                    begin
                        $display("%0t: word_index expected %0d actual %0d", $time,
                            exp_w.word_index, out_ch.word_index);
                        error_count++;
                    end
                    if (exp_w.last_word !== out_ch.last_word)
                    begin
                        $display("%0t: last_word expected %0b actual %0b", $time,
                            exp_w.last_word, out_ch.last_word);
                        error_count++;
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    task automatic queue_msg(int len, bit tail_byte, int pat);
        msg_item_t it;
        for (int i = 0; i < len; i++)
        begin
            case (pat)
                0: it.msg_byte = 8'h00;
                1: it.msg_byte = 8'hff;
                default: it.msg_byte = 8'($urandom);
            endcase
            it.byte_valid = 1'b1;
            // the final byte may ride on the end-of-message item
            it.end_of_message = tail_byte && (i == len - 1);
            pending_bytes.push_back(it);
        end
        if (!tail_byte || len == 0)
            pending_bytes.push_back('{8'($urandom), 1'b0, 1'b1});
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || in_ch.valid || digest_queue.size() > 0)
            @(posedge clk);
    endtask

    // message lengths, some of them at the padding boundaries
    function automatic int pick_len();
        case ($urandom_range(5))
            0: return $urandom_range(55, 0);
            1: return $urandom_range(57, 54);
            2: return $urandom_range(65, 62);
            3: return $urandom_range(121, 118);
            default: return $urandom_range(20, 0);
        endcase
    endfunction

    initial
    begin
        int sent;
        int len;
        msg_item_t noise;
        hash_restart();
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty message, empty tail after bytes, byte on final item,
        // all-zero and all-one bytes, idle items, marker past byte 55,
        // 64th byte on the final item
        send_idle_pct = 11;
        recv_idle_pct = 67;
        queue_msg(0, 1'b0, 2);
        pending_bytes.push_back('{8'hff, 1'b0, 1'b0});
        pending_bytes.push_back('{8'h00, 1'b0, 1'b0});
        queue_msg(3, 1'b1, 2);
        queue_msg(1, 1'b0, 1);
        queue_msg(2, 1'b1, 0);
        queue_msg(56, 1'b0, 1);
        queue_msg(64, 1'b1, 2);
        wait_drained();

        // long receiver hold-off while the sender keeps offering messages
        hold_off = 1'b1;
        send_idle_pct = 0;
        queue_msg(5, 1'b1, 2);
        queue_msg(4, 1'b0, 2);
        queue_msg(2, 1'b1, 2);
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
        wait_drained();

        // random part over three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 11 : 0;
            sent = 0;
            while (sent < RAND_ITEMS / 3)
            begin
                if ($urandom_range(9) == 0)
                begin
                    noise = '{8'($urandom), 1'b0, 1'b0};
                    pending_bytes.push_back(noise);
                    sent++;
                end
                else
                begin
                    len = pick_len();
                    // keep the phase near its item budget
                    if (len + 1 > RAND_ITEMS / 3 - sent)
                        len = RAND_ITEMS / 3 - sent - 1;
                    queue_msg(len, 1'($urandom), 2);
                    sent += len + 1;
                end
            end
            wait_drained();
        end

        repeat (200) @(posedge clk);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
